// File: hdl/sstep_pkg.sv
// ----------------------------------------------------------------------------
// sstep_pkg
// shared widths, register indexes, image size type and range check for the
// span texel stepper
// ----------------------------------------------------------------------------
package sstep_pkg;

	localparam int COORD_W   = 14;
	localparam int LEN_W     = 7;
	localparam int SIZE_W    = 13;
	localparam int CFG_IDX_W = 1;

	// log2 of the step divider radix: quotient bits settled per cycle
	localparam int DIV_BITS = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd256;

	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} img_size_t;

	// 0 <= x < width and 0 <= y < height
	function automatic logic in_image(logic signed [COORD_W:0] x,
	                                  logic signed [COORD_W:0] y,
	                                  img_size_t sz);
		logic ok_x;
		logic ok_y;
		ok_x = !x[COORD_W] && (x[COORD_W-1:0] < COORD_W'(sz.width));
		ok_y = !y[COORD_W] && (y[COORD_W-1:0] < COORD_W'(sz.height));
		return ok_x && ok_y;
	endfunction

endpackage

// File: hdl/sstep_fifo.sv
// ----------------------------------------------------------------------------
// sstep_fifo
// two-entry span descriptor queue between the front end and the stepper
// ----------------------------------------------------------------------------
module sstep_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              empty
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: hdl/sstep_front.sv
// ----------------------------------------------------------------------------
// sstep_front
// takes span endpoints, keeps the previous point and works out the per-axis
// fixed-point step with a radix-16 restoring divider
// ----------------------------------------------------------------------------
module sstep_front #(
	parameter int FRAC_BITS = 7,
	parameter int MAX_SPAN  = 64
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  sstep_pkg::img_size_t                            img,
	input  logic                                            push,
	output logic                                            full,
	input  logic signed [sstep_pkg::COORD_W-1:0]            end_x,
	input  logic signed [sstep_pkg::COORD_W-1:0]            end_y,
	input  logic [sstep_pkg::LEN_W-1:0]                     span_len,
	output logic                                            d_valid,
	input  logic                                            d_ready,
	output logic signed [sstep_pkg::COORD_W-1:0]            d_base_x,
	output logic signed [sstep_pkg::COORD_W-1:0]            d_base_y,
	output logic signed [sstep_pkg::COORD_W+FRAC_BITS:0]    d_step_x,
	output logic signed [sstep_pkg::COORD_W+FRAC_BITS:0]    d_step_y,
	output logic [$clog2(MAX_SPAN)-1:0]                     d_cnt,
	output logic signed [sstep_pkg::COORD_W-1:0]            d_end_x,
	output logic signed [sstep_pkg::COORD_W-1:0]            d_end_y,
	output logic                                            d_end_ok
);

	localparam int CW      = sstep_pkg::COORD_W;
	localparam int LW      = sstep_pkg::LEN_W;
	localparam int RB      = sstep_pkg::DIV_BITS;
	localparam int DIFF_W  = CW + 1;
	localparam int MAG_W   = CW + FRAC_BITS;
	localparam int DIV_CYC = (MAG_W + RB - 1) / RB;
	localparam int PAD_W   = DIV_CYC * RB;
	localparam int STEP_W  = MAG_W + 1;
	localparam int REM_W   = LW + 1;
	localparam int CNT_W   = $clog2(MAX_SPAN);
	localparam int CYC_W   = $clog2(DIV_CYC + 1);
	localparam int ITER_W  = REM_W + 2 * PAD_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]             state_q;
	logic [CYC_W-1:0]       cyc_q;
	logic signed [CW-1:0]   prev_x_q;
	logic signed [CW-1:0]   prev_y_q;
	logic signed [CW-1:0]   base_x_q;
	logic signed [CW-1:0]   base_y_q;
	logic signed [CW-1:0]   end_x_q;
	logic signed [CW-1:0]   end_y_q;
	logic                   end_ok_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [LW-1:0]          div_n_q;
	logic                   neg_x_q;
	logic                   neg_y_q;
	logic [PAD_W-1:0]       dvd_x_q;
	logic [PAD_W-1:0]       dvd_y_q;
	logic [REM_W-1:0]       rem_x_q;
	logic [REM_W-1:0]       rem_y_q;
	logic [PAD_W-1:0]       quo_x_q;
	logic [PAD_W-1:0]       quo_y_q;

	logic                   accept;
	logic [LW-1:0]          n_sat;
	logic signed [DIFF_W-1:0] diff_x;
	logic signed [DIFF_W-1:0] diff_y;
	logic [DIFF_W-1:0]      mag_x;
	logic [DIFF_W-1:0]      mag_y;
	logic                   ok_now;
	logic [ITER_W-1:0]      it_x;
	logic [ITER_W-1:0]      it_y;
	logic signed [STEP_W-1:0] q_x;
	logic signed [STEP_W-1:0] q_y;

	// RB dependent restoring steps on a narrow remainder
	function automatic logic [ITER_W-1:0] div_iter(logic [REM_W-1:0] r_in,
	                                               logic [PAD_W-1:0] d_in,
	                                               logic [PAD_W-1:0] q_in,
	                                               logic [LW-1:0] n);
		logic [REM_W-1:0] r;
		logic [PAD_W-1:0] d;
		logic [PAD_W-1:0] q;
		r = r_in;
		d = d_in;
		q = q_in;
		for (int k = 0; k < RB; k++) begin
			r = {r[REM_W-2:0], d[PAD_W-1]};
			d = {d[PAD_W-2:0], 1'b0};
			if (r >= {1'b0, n}) begin
				r = r - {1'b0, n};
				q = {q[PAD_W-2:0], 1'b1};
			end else begin
				q = {q[PAD_W-2:0], 1'b0};
			end
		end
		return {r, d, q};
	endfunction

	assign full   = (state_q != ST_IDLE);
	assign accept = push && !full;

	// zero length behaves as one, long spans clip to the maximum
	always_comb begin
		if (span_len == '0) begin
			n_sat = LW'(1);
		end else if (span_len > LW'(MAX_SPAN)) begin
			n_sat = LW'(MAX_SPAN);
		end else begin
			n_sat = span_len;
		end
	end

	assign diff_x = DIFF_W'(end_x) - DIFF_W'(prev_x_q);
	assign diff_y = DIFF_W'(end_y) - DIFF_W'(prev_y_q);
	assign mag_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
	assign mag_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
	assign ok_now = sstep_pkg::in_image(DIFF_W'(end_x), DIFF_W'(end_y), img);

	assign it_x = div_iter(rem_x_q, dvd_x_q, quo_x_q, div_n_q);
	assign it_y = div_iter(rem_y_q, dvd_y_q, quo_y_q, div_n_q);

	// truncation toward zero: divide magnitudes, then restore the sign
	assign q_x = $signed({1'b0, quo_x_q[MAG_W-1:0]});
	assign q_y = $signed({1'b0, quo_y_q[MAG_W-1:0]});

	assign d_valid  = (state_q == ST_DONE);
	assign d_base_x = base_x_q;
	assign d_base_y = base_y_q;
	assign d_step_x = neg_x_q ? -q_x : q_x;
	assign d_step_y = neg_y_q ? -q_y : q_y;
	assign d_cnt    = cnt_q;
	assign d_end_x  = end_x_q;
	assign d_end_y  = end_y_q;
	assign d_end_ok = end_ok_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			base_x_q <= prev_x_q;
			base_y_q <= prev_y_q;
			end_x_q  <= ok_now ? end_x : '0;
			end_y_q  <= ok_now ? end_y : '0;
			end_ok_q <= ok_now;
			cnt_q    <= CNT_W'(n_sat - LW'(1));
			div_n_q  <= n_sat;
			neg_x_q  <= diff_x[DIFF_W-1];
			neg_y_q  <= diff_y[DIFF_W-1];
			dvd_x_q  <= PAD_W'({mag_x[CW-1:0], {FRAC_BITS{1'b0}}});
			dvd_y_q  <= PAD_W'({mag_y[CW-1:0], {FRAC_BITS{1'b0}}});
			rem_x_q  <= '0;
			rem_y_q  <= '0;
			quo_x_q  <= '0;
			quo_y_q  <= '0;
		end else if (state_q == ST_DIV) begin
			{rem_x_q, dvd_x_q, quo_x_q} <= it_x;
			{rem_y_q, dvd_y_q, quo_y_q} <= it_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cyc_q    <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						cyc_q   <= '0;
						if (ok_now) begin
							prev_x_q <= end_x;
							prev_y_q <= end_y;
						end
					end
				end
				ST_DIV: begin
					cyc_q <= cyc_q + CYC_W'(1);
					if (cyc_q == CYC_W'(DIV_CYC - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (d_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/sstep_back.sv
// ----------------------------------------------------------------------------
// sstep_back
// walks span by span into the result register, a texel per cycle while popped
// ----------------------------------------------------------------------------
module sstep_back #(
	parameter int FRAC_BITS = 7,
	parameter int MAX_SPAN  = 64
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  sstep_pkg::img_size_t                            img,
	input  logic                                            q_empty,
	output logic                                            q_rd,
	input  logic signed [sstep_pkg::COORD_W-1:0]            q_base_x,
	input  logic signed [sstep_pkg::COORD_W-1:0]            q_base_y,
	input  logic signed [sstep_pkg::COORD_W+FRAC_BITS:0]    q_step_x,
	input  logic signed [sstep_pkg::COORD_W+FRAC_BITS:0]    q_step_y,
	input  logic [$clog2(MAX_SPAN)-1:0]                     q_cnt,
	input  logic signed [sstep_pkg::COORD_W-1:0]            q_end_x,
	input  logic signed [sstep_pkg::COORD_W-1:0]            q_end_y,
	input  logic                                            q_end_ok,
	output logic                                            empty,
	input  logic                                            pop,
	output logic signed [sstep_pkg::COORD_W-1:0]            texel_x,
	output logic signed [sstep_pkg::COORD_W-1:0]            texel_y,
	output logic                                            in_range,
	output logic                                            last
);

	localparam int CW     = sstep_pkg::COORD_W;
	localparam int STEP_W = CW + FRAC_BITS + 1;
	localparam int ACC_W  = CW + FRAC_BITS + 2;
	localparam int CNT_W  = $clog2(MAX_SPAN);

	logic                     busy_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [ACC_W-1:0]  acc_x_q;
	logic signed [ACC_W-1:0]  acc_y_q;
	logic signed [STEP_W-1:0] step_x_q;
	logic signed [STEP_W-1:0] step_y_q;
	logic signed [CW-1:0]     end_x_q;
	logic signed [CW-1:0]     end_y_q;
	logic                     end_ok_q;
	logic                     out_valid_q;
	logic signed [CW-1:0]     tx_q;
	logic signed [CW-1:0]     ty_q;
	logic                     ok_q;
	logic                     last_q;

	logic                     advance;
	logic                     at_end;
	logic                     load;
	logic signed [CW:0]       fx;
	logic signed [CW:0]       fy;
	logic                     mid_ok;
	logic signed [ACC_W-1:0]  first_x;
	logic signed [ACC_W-1:0]  first_y;

	assign advance = busy_q && (!out_valid_q || pop);
	assign at_end  = (cnt_q == '0);
	assign load    = !q_empty && (!busy_q || (advance && at_end));
	assign q_rd    = load;

	// floor of the fixed-point position
	assign fx     = acc_x_q[FRAC_BITS+CW:FRAC_BITS];
	assign fy     = acc_y_q[FRAC_BITS+CW:FRAC_BITS];
	assign mid_ok = sstep_pkg::in_image(fx, fy, img);

	// first interior texel sits one step past the start point
	assign first_x = ACC_W'($signed({q_base_x, {FRAC_BITS{1'b0}}})) + ACC_W'(q_step_x);
	assign first_y = ACC_W'($signed({q_base_y, {FRAC_BITS{1'b0}}})) + ACC_W'(q_step_y);

	assign empty    = !out_valid_q;
	assign texel_x  = tx_q;
	assign texel_y  = ty_q;
	assign in_range = ok_q;
	assign last     = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_q    <= q_cnt;
			acc_x_q  <= first_x;
			acc_y_q  <= first_y;
			step_x_q <= q_step_x;
			step_y_q <= q_step_y;
			end_x_q  <= q_end_x;
			end_y_q  <= q_end_y;
			end_ok_q <= q_end_ok;
		end else if (advance && !at_end) begin
			cnt_q   <= cnt_q - CNT_W'(1);
			acc_x_q <= acc_x_q + ACC_W'(step_x_q);
			acc_y_q <= acc_y_q + ACC_W'(step_y_q);
		end
		if (advance) begin
			if (at_end) begin
				tx_q   <= end_x_q;
				ty_q   <= end_y_q;
				ok_q   <= end_ok_q;
				last_q <= 1'b1;
			end else begin
				tx_q   <= mid_ok ? fx[CW-1:0] : '0;
				ty_q   <= mid_ok ? fy[CW-1:0] : '0;
				ok_q   <= mid_ok;
				last_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (advance && at_end) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/scanline_span_texel_stepper.sv
// ----------------------------------------------------------------------------
// scanline_span_texel_stepper
// fixed-point span stepper: interpolated texels between successive endpoints
// ----------------------------------------------------------------------------
// Each pushed item names a span endpoint and a span length n (0 counts as 1,
// lengths above MAX_SPAN clip to MAX_SPAN). The block pops out n-1 texels
// stepped from the last in-range endpoint in FRAC_BITS fixed point, then the
// endpoint itself with last set; a texel outside the image comes out as 0,0
// with in_range low. The front end, built around a radix-16 step divider,
// takes no new item until the last one's step is worked out and handed to
// the queue; the stepper behind a two-deep span queue gives one result per
// cycle while pop is held high and a span is waiting. The image size may
// only be written while nothing is in flight.
// ----------------------------------------------------------------------------
module scanline_span_texel_stepper #(
	parameter int FRAC_BITS = 7,
	parameter int MAX_SPAN  = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_wr_en,
	input  logic [sstep_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sstep_pkg::SIZE_W-1:0]          cfg_data,
	// span input
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [sstep_pkg::COORD_W-1:0]  end_x,
	input  logic signed [sstep_pkg::COORD_W-1:0]  end_y,
	input  logic [sstep_pkg::LEN_W-1:0]           span_len,
	// texel results
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [sstep_pkg::COORD_W-1:0]  texel_x,
	output logic signed [sstep_pkg::COORD_W-1:0]  texel_y,
	output logic                                  in_range,
	output logic                                  last
);

	localparam int CW     = sstep_pkg::COORD_W;
	localparam int STEP_W = CW + FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(MAX_SPAN);
	// span descriptor: base x/y, step x/y, count, endpoint x/y, endpoint ok
	localparam int DESC_W = 4 * CW + 2 * STEP_W + CNT_W + 1;

	sstep_pkg::img_size_t img_q;

	// front end to queue
	logic                     f_valid;
	logic                     f_ready;
	logic signed [CW-1:0]     f_base_x;
	logic signed [CW-1:0]     f_base_y;
	logic signed [STEP_W-1:0] f_step_x;
	logic signed [STEP_W-1:0] f_step_y;
	logic [CNT_W-1:0]         f_cnt;
	logic signed [CW-1:0]     f_end_x;
	logic signed [CW-1:0]     f_end_y;
	logic                     f_end_ok;
	logic [DESC_W-1:0]        f_desc;

	// queue to stepper
	logic                     q_full;
	logic                     q_empty;
	logic                     q_rd;
	logic [DESC_W-1:0]        q_desc;
	logic signed [CW-1:0]     q_base_x;
	logic signed [CW-1:0]     q_base_y;
	logic signed [STEP_W-1:0] q_step_x;
	logic signed [STEP_W-1:0] q_step_y;
	logic [CNT_W-1:0]         q_cnt;
	logic signed [CW-1:0]     q_end_x;
	logic signed [CW-1:0]     q_end_y;
	logic                     q_end_ok;

	// image size registers, a two-entry index leaves no unused codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_q.width  <= sstep_pkg::SIZE_RESET;
			img_q.height <= sstep_pkg::SIZE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sstep_pkg::CFG_IMAGE_WIDTH:  img_q.width  <= cfg_data;
				sstep_pkg::CFG_IMAGE_HEIGHT: img_q.height <= cfg_data;
			endcase
		end
	end

	// front end: previous point, endpoint check and step division
	sstep_front #(
		.FRAC_BITS (FRAC_BITS),
		.MAX_SPAN  (MAX_SPAN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.img      (img_q),
		.push     (push),
		.full     (full),
		.end_x    (end_x),
		.end_y    (end_y),
		.span_len (span_len),
		.d_valid  (f_valid),
		.d_ready  (f_ready),
		.d_base_x (f_base_x),
		.d_base_y (f_base_y),
		.d_step_x (f_step_x),
		.d_step_y (f_step_y),
		.d_cnt    (f_cnt),
		.d_end_x  (f_end_x),
		.d_end_y  (f_end_y),
		.d_end_ok (f_end_ok)
	);

	assign f_ready = !q_full;
	assign f_desc  = {f_base_x, f_base_y, f_step_x, f_step_y, f_cnt,
	                  f_end_x, f_end_y, f_end_ok};

	// short descriptor queue so the divider and the stepper stall apart
	sstep_fifo #(
		.DATA_W (DESC_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data (f_desc),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_desc),
		.empty   (q_empty)
	);

	assign {q_base_x, q_base_y, q_step_x, q_step_y, q_cnt,
	        q_end_x, q_end_y, q_end_ok} = q_desc;

	// stepper: one texel per transfer, endpoint last
	sstep_back #(
		.FRAC_BITS (FRAC_BITS),
		.MAX_SPAN  (MAX_SPAN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.img      (img_q),
		.q_empty  (q_empty),
		.q_rd     (q_rd),
		.q_base_x (q_base_x),
		.q_base_y (q_base_y),
		.q_step_x (q_step_x),
		.q_step_y (q_step_y),
		.q_cnt    (q_cnt),
		.q_end_x  (q_end_x),
		.q_end_y  (q_end_y),
		.q_end_ok (q_end_ok),
		.empty    (empty),
		.pop      (pop),
		.texel_x  (texel_x),
		.texel_y  (texel_y),
		.in_range (in_range),
		.last     (last)
	);

endmodule
